/* src/lla_pkg.sv */
`timescale 1ns / 1ps
// Package for the Lambert light accumulator: control word types, codes and the microcode ROM.
// Depends on nothing; imported by lambert_light_accumulator.
package lla_pkg;

  localparam int CH_W   = 16;  // color, gain and vector width
  localparam int SUM_W  = 20;  // light sum width
  localparam int PC_W   = 5;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_LIGHT = 1'b1;

  localparam logic [1:0] CFG_AMBIENT_GAIN  = 2'd0;
  localparam logic [1:0] CFG_DIFFUSE_GAIN  = 2'd1;
  localparam logic [1:0] CFG_IGNORE_LIGHTS = 2'd2;

  localparam logic [CH_W-1:0] KA_RESET = 16'd819;
  localparam logic [CH_W-1:0] KD_RESET = 16'd3277;

  typedef logic [PC_W-1:0] pc_t;

  // Program entry points.
  localparam pc_t P_LIGHT = 5'd0;
  localparam pc_t P_CHECK = 5'd11;
  localparam pc_t P_EMIT  = 5'd12;
  localparam pc_t P_IGN   = 5'd17;
  localparam pc_t P_HALT  = 5'd20;

  // Multiplier operand A: input vector, surface normal, cosine, shifted product, light sum.
  typedef enum logic [2:0] {MA_VEC, MA_NORM, MA_COS, MA_SHIFT, MA_SUM} ma_sel_t;
  // Multiplier operand B: surface normal, light intensity, Kd, surface color.
  typedef enum logic [1:0] {MB_NORM, MB_CHAN, MB_KD, MB_COLOR} mb_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
  typedef enum logic [2:0] {
    ACT_NONE, ACT_AMB, ACT_DIF, ACT_IGN, ACT_RES, ACT_PUB, ACT_HALT
  } act_t;
  typedef enum logic [1:0] {JC_NONE, JC_ALWAYS, JC_NOT_LIT, JC_NOT_LAST} jc_t;

  typedef struct packed {
    ma_sel_t    ma;
    mb_sel_t    mb;
    logic [1:0] mch;   // channel for the multiplier operands
    acc_op_t    acc;
    act_t       act;
    logic [1:0] sch;   // channel for the sum or result action
    jc_t        jc;
    pc_t        tgt;
  } uword_t;

  function automatic uword_t mk_word(input ma_sel_t ma, input mb_sel_t mb,
                                     input logic [1:0] mch, input acc_op_t acc,
                                     input act_t act, input logic [1:0] sch,
                                     input jc_t jc, input pc_t tgt);
    uword_t w;
    w.ma  = ma;
    w.mb  = mb;
    w.mch = mch;
    w.acc = acc;
    w.act = act;
    w.sch = sch;
    w.jc  = jc;
    w.tgt = tgt;
    return w;
  endfunction

  // The microcode ROM. Every step issues one product; the product register feeds the next step.
  function automatic uword_t ucode(input pc_t addr);
    uword_t w;
    unique case (addr)
      // Light item: dot product while ambient terms are added.
      5'd0:  w = mk_word(MA_VEC, MB_NORM, 2'd0, ACC_HOLD, ACT_AMB, 2'd0, JC_NONE, P_LIGHT);
      5'd1:  w = mk_word(MA_VEC, MB_NORM, 2'd1, ACC_LOAD, ACT_AMB, 2'd1, JC_NONE, P_LIGHT);
      5'd2:  w = mk_word(MA_VEC, MB_NORM, 2'd2, ACC_ADD, ACT_AMB, 2'd2, JC_NONE, P_LIGHT);
      5'd3:  w = mk_word(MA_VEC, MB_NORM, 2'd0, ACC_ADD, ACT_NONE, 2'd0, JC_NONE, P_LIGHT);
      // Diffuse terms, two products per channel.
      5'd4:  w = mk_word(MA_COS, MB_CHAN, 2'd0, ACC_HOLD, ACT_NONE, 2'd0, JC_NOT_LIT, P_CHECK);
      5'd5:  w = mk_word(MA_SHIFT, MB_KD, 2'd0, ACC_HOLD, ACT_NONE, 2'd0, JC_NONE, P_LIGHT);
      5'd6:  w = mk_word(MA_COS, MB_CHAN, 2'd1, ACC_HOLD, ACT_DIF, 2'd0, JC_NONE, P_LIGHT);
      5'd7:  w = mk_word(MA_SHIFT, MB_KD, 2'd1, ACC_HOLD, ACT_NONE, 2'd0, JC_NONE, P_LIGHT);
      5'd8:  w = mk_word(MA_COS, MB_CHAN, 2'd2, ACC_HOLD, ACT_DIF, 2'd1, JC_NONE, P_LIGHT);
      5'd9:  w = mk_word(MA_SHIFT, MB_KD, 2'd2, ACC_HOLD, ACT_NONE, 2'd0, JC_NONE, P_LIGHT);
      5'd10: w = mk_word(MA_SHIFT, MB_KD, 2'd0, ACC_HOLD, ACT_DIF, 2'd2, JC_NONE, P_LIGHT);
      5'd11: w = mk_word(MA_SUM, MB_COLOR, 2'd0, ACC_HOLD, ACT_NONE, 2'd0, JC_NOT_LAST, P_HALT);
      // Emit: light sum times surface color, then publish.
      5'd12: w = mk_word(MA_SUM, MB_COLOR, 2'd0, ACC_HOLD, ACT_NONE, 2'd0, JC_NONE, P_LIGHT);
      5'd13: w = mk_word(MA_SUM, MB_COLOR, 2'd1, ACC_HOLD, ACT_RES, 2'd0, JC_NONE, P_LIGHT);
      5'd14: w = mk_word(MA_SUM, MB_COLOR, 2'd2, ACC_HOLD, ACT_RES, 2'd1, JC_NONE, P_LIGHT);
      5'd15: w = mk_word(MA_SUM, MB_COLOR, 2'd0, ACC_HOLD, ACT_RES, 2'd2, JC_NONE, P_LIGHT);
      5'd16: w = mk_word(MA_SUM, MB_COLOR, 2'd0, ACC_HOLD, ACT_PUB, 2'd0, JC_NONE, P_LIGHT);
      // Ignore-lights begin: nz squared times Kd plus Ka, then emit.
      5'd17: w = mk_word(MA_NORM, MB_NORM, 2'd2, ACC_HOLD, ACT_NONE, 2'd0, JC_NONE, P_LIGHT);
      5'd18: w = mk_word(MA_SHIFT, MB_KD, 2'd0, ACC_HOLD, ACT_NONE, 2'd0, JC_NONE, P_LIGHT);
      5'd19: w = mk_word(MA_SUM, MB_COLOR, 2'd0, ACC_HOLD, ACT_IGN, 2'd0, JC_ALWAYS, P_EMIT);
      default: w = mk_word(MA_SUM, MB_COLOR, 2'd0, ACC_HOLD, ACT_HALT, 2'd0, JC_NONE, P_LIGHT);
    endcase
    return w;
  endfunction

endpackage

/* src/lambert_light_accumulator.sv */
`timescale 1ns / 1ps
// Lambert diffuse shading accumulator: microcoded sequencer around one shared multiplier.
// Depends on lla_pkg for the control word types and the microcode ROM.
//
//   Channel   Ports                                   Direction  Beat
//   in        in_valid/in_ready, in_cmd .. in_last_*  to block   one begin or light item
//   out       out_valid/out_ready, out_r/g/b           from block one shaded color
//   cfg       cfg_we, cfg_index, cfg_data              to block   one register write
//
// A begin beat that needs no result, or a light beat while lights are ignored, is
// finished in its accept cycle. A light beat runs the dot-product and diffuse steps,
// jumping past the diffuse products when not lit, then emit when it is the last; an
// ignore-lights begin runs its own steps then emit, a begin with no lights just emit.
// Each step issues one product on the one multiplier. in_ready is low while the program
// runs and while a publish waits for the output register, which holds the previous
// beat until out_ready. Reset is synchronous, active low and restores the gains.
module lambert_light_accumulator
  import lla_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [CH_W-1:0]  in_vec_x,
  input  logic [CH_W-1:0]  in_vec_y,
  input  logic [CH_W-1:0]  in_vec_z,
  input  logic [CH_W-1:0]  in_chan_r,
  input  logic [CH_W-1:0]  in_chan_g,
  input  logic [CH_W-1:0]  in_chan_b,
  input  logic             in_ambient_on,
  input  logic             in_diffuse_on,
  input  logic             in_last_light,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CH_W-1:0]  out_r,
  output logic [CH_W-1:0]  out_g,
  output logic [CH_W-1:0]  out_b,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CH_W-1:0]  cfg_data
);

  // The dot product of two Q3.F vectors stays below 2^32 in magnitude, so the
  // positive part, shifted by F, gives a cosine of 32-F bits. The widest operand
  // the multiplier sees is intensity*cos shifted by F, which is 48-2F bits.
  localparam int DOT_W  = 34;
  localparam int DPOS_W = 32;
  localparam int COS_W  = DPOS_W - FRAC_BITS;
  localparam int T1_W   = 48 - 2 * FRAC_BITS;
  localparam int A_UW   = (T1_W > SUM_W) ? T1_W : SUM_W;
  localparam int AW     = A_UW + 1;
  localparam int BW     = CH_W + 1;
  localparam int PW     = AW + BW;
  localparam int SH_W   = PW - FRAC_BITS;

  // Configuration registers.
  logic [CH_W-1:0] ka_r, kd_r;
  logic            ign_r;

  // Point state and the latched light beat.
  logic [CH_W-1:0]  norm_r  [3];
  logic [CH_W-1:0]  color_r [3];
  logic [SUM_W-1:0] sum_r   [3];
  logic [CH_W-1:0]  vec_r   [3];
  logic [CH_W-1:0]  inten_r [3];
  logic             amb_r, dif_r, last_r;

  // Datapath registers.
  logic signed [DOT_W-1:0] acc_r;
  logic signed [PW-1:0]    prod_r;
  logic [CH_W-1:0]         hold_r [3];
  logic [CH_W-1:0]         obuf_r [3];
  logic                    out_valid_r;

  // Sequencer.
  logic busy_r, busy_nxt;
  pc_t  pc_r, pc_nxt;

  uword_t uw_c;
  logic   accept_c, start_c, stall_c, jump_c, lit_c, nz_pos_c;
  pc_t    start_pc_c;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_c, shift_c;
  logic [SH_W-1:0]      sh_u;
  logic                 sh_big20, sh_big16;
  logic [COS_W-1:0]     cos_c;
  logic [SUM_W-1:0]     sum_sel;
  logic [SUM_W:0]       amb_add, dif_add, ign_add;
  logic [SUM_W-1:0]     amb_sat, dif_sat, ign_sat;
  logic [CH_W-1:0]      res_sat;

  assign uw_c     = ucode(pc_r);
  assign in_ready = !busy_r;
  assign accept_c = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_r     = obuf_r[0];
  assign out_g     = obuf_r[1];
  assign out_b     = obuf_r[2];

  // Decide at accept whether the beat needs the program and where it enters.
  always_comb begin
    start_c    = 1'b0;
    start_pc_c = P_LIGHT;
    if (in_cmd == CMD_BEGIN) begin
      if (ign_r) begin
        start_c    = 1'b1;
        start_pc_c = P_IGN;
      end else if (in_last_light) begin
        // Sums are cleared by the begin, so the emit program yields black.
        start_c    = 1'b1;
        start_pc_c = P_EMIT;
      end
    end else if (!ign_r) begin
      start_c    = 1'b1;
      start_pc_c = P_LIGHT;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    case (uw_c.ma)
      MA_VEC:   mul_a = AW'($signed(vec_r[uw_c.mch]));
      MA_NORM:  mul_a = AW'($signed(norm_r[uw_c.mch]));
      MA_COS:   mul_a = $signed(AW'(cos_c));
      MA_SHIFT: mul_a = shift_c[AW-1:0];
      MA_SUM:   mul_a = $signed(AW'(sum_r[uw_c.mch]));
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    mul_b = '0;
    case (uw_c.mb)
      MB_NORM:  mul_b = BW'($signed(norm_r[uw_c.mch]));
      MB_CHAN:  mul_b = $signed({1'b0, inten_r[uw_c.mch]});
      MB_KD:    mul_b = $signed({1'b0, kd_r});
      MB_COLOR: mul_b = $signed({1'b0, color_r[uw_c.mch]});
      default:  mul_b = '0;
    endcase
  end

  assign prod_c  = mul_a * mul_b;
  // Every product that gets shifted down is non-negative, so the low bits are the value.
  assign shift_c = prod_r >>> FRAC_BITS;
  assign sh_u    = shift_c[SH_W-1:0];
  assign sh_big20 = |sh_u[SH_W-1:SUM_W];
  assign sh_big16 = |sh_u[SH_W-1:CH_W];

  assign cos_c    = acc_r[DPOS_W-1:FRAC_BITS];
  assign lit_c    = dif_r && (acc_r > 0);
  assign nz_pos_c = $signed(norm_r[2]) > 0;

  // Saturating adders into the light sum.
  assign sum_sel = sum_r[uw_c.sch];
  assign amb_add = {1'b0, sum_sel} + {5'b0, inten_r[uw_c.sch]};
  assign dif_add = {1'b0, sum_sel} + {1'b0, sh_u[SUM_W-1:0]};
  assign ign_add = {1'b0, sh_u[SUM_W-1:0]} + {5'b0, ka_r};
  assign amb_sat = amb_add[SUM_W] ? '1 : amb_add[SUM_W-1:0];
  assign dif_sat = (sh_big20 || dif_add[SUM_W]) ? '1 : dif_add[SUM_W-1:0];
  assign ign_sat = (sh_big20 || ign_add[SUM_W]) ? '1 : ign_add[SUM_W-1:0];
  assign res_sat = sh_big16 ? '1 : sh_u[CH_W-1:0];

  // Sequencer: step, jump, stall at publish while the output register is full and out_ready is low.
  assign stall_c = busy_r && (uw_c.act == ACT_PUB) && out_valid_r && !out_ready;

  always_comb begin
    jump_c = 1'b0;
    unique case (uw_c.jc)
      JC_NONE:     jump_c = 1'b0;
      JC_ALWAYS:   jump_c = 1'b1;
      JC_NOT_LIT:  jump_c = !lit_c;
      JC_NOT_LAST: jump_c = !last_r;
      default:     jump_c = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (busy_r) begin
      if (uw_c.act == ACT_HALT) begin
        busy_nxt = 1'b0;
      end else if (uw_c.act == ACT_PUB) begin
        if (!stall_c) busy_nxt = 1'b0;
      end else if (jump_c) begin
        pc_nxt = uw_c.tgt;
      end else begin
        pc_nxt = pc_r + pc_t'(1);
      end
    end else if (accept_c && start_c) begin
      busy_nxt = 1'b1;
      pc_nxt   = start_pc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= P_LIGHT;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ka_r  <= KA_RESET;
      kd_r  <= KD_RESET;
      ign_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AMBIENT_GAIN:  ka_r  <= cfg_data;
        CFG_DIFFUSE_GAIN:  kd_r  <= cfg_data;
        CFG_IGNORE_LIGHTS: ign_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Surface state and light sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        norm_r[c]  <= '0;
        color_r[c] <= '0;
        sum_r[c]   <= '0;
      end
    end else if (accept_c && in_cmd == CMD_BEGIN) begin
      norm_r[0]  <= in_vec_x;
      norm_r[1]  <= in_vec_y;
      norm_r[2]  <= in_vec_z;
      color_r[0] <= in_chan_r;
      color_r[1] <= in_chan_g;
      color_r[2] <= in_chan_b;
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
    end else if (busy_r) begin
      case (uw_c.act)
        ACT_AMB: if (amb_r) sum_r[uw_c.sch] <= amb_sat;
        ACT_DIF: sum_r[uw_c.sch] <= dif_sat;
        ACT_IGN: begin
          for (int c = 0; c < 3; c++) sum_r[c] <= nz_pos_c ? ign_sat : '0;
        end
        ACT_PUB: begin
          if (!stall_c) begin
            for (int c = 0; c < 3; c++) sum_r[c] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Latched light beat and datapath registers.
  always_ff @(posedge clk) begin
    if (accept_c && in_cmd == CMD_LIGHT) begin
      vec_r[0]   <= in_vec_x;
      vec_r[1]   <= in_vec_y;
      vec_r[2]   <= in_vec_z;
      inten_r[0] <= in_chan_r;
      inten_r[1] <= in_chan_g;
      inten_r[2] <= in_chan_b;
      amb_r      <= in_ambient_on;
      dif_r      <= in_diffuse_on;
    end
    if (accept_c) last_r <= in_last_light;
    if (busy_r) begin
      prod_r <= prod_c;
      case (uw_c.acc)
        ACC_LOAD: acc_r <= prod_r[DOT_W-1:0];
        ACC_ADD:  acc_r <= acc_r + prod_r[DOT_W-1:0];
        default: ;
      endcase
      if (uw_c.act == ACT_RES) hold_r[uw_c.sch] <= res_sat;
    end
    if (busy_r && uw_c.act == ACT_PUB && !stall_c) begin
      for (int c = 0; c < 3; c++) obuf_r[c] <= hold_r[c];
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (busy_r && uw_c.act == ACT_PUB && !stall_c) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // A publish that is not stalled leaves a valid beat in the output register.
  a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uw_c.act == ACT_PUB && !stall_c |=> out_valid_r)
    else $error("publish did not raise out_valid");

  // A publish leaves the light sums cleared for the next point.
  a_pub_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && uw_c.act == ACT_PUB && !stall_c |=>
      sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0)
    else $error("light sums not cleared after publish");

  // The program counter stays inside the microcode while running.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pc_r <= P_HALT)
    else $error("program counter out of range");

  // A stalled publish keeps the sequencer parked on the publish step.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall_c |=> busy_r && $stable(pc_r))
    else $error("sequencer moved during a stalled publish");

endmodule
